### design/tphr_pkg.sv
// Package for the timestamped position history rewind core.
// Holds request and status codes, widths and the front-to-back command type.
`default_nettype none
package tphr_pkg;
    localparam int NumClientsDef   = 64;
    localparam int HistoryDepthDef = 128;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_LEN  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_REWIND = 1'b1;
    localparam logic [9:0]  FRAME_LEN_RST  = 10'd50;
    localparam logic [15:0] MAX_REWIND_RST = 16'd1000;

    typedef enum logic [0:0] {REQ_PUSH = 1'b0, REQ_LOOKUP = 1'b1} t_req;
    typedef enum logic [1:0] {
        ST_INTERP = 2'd0, ST_OLDEST = 2'd1, ST_RECENT = 2'd2, ST_NOHIST = 2'd3
    } t_status;

    // classified command handed from the front to the back
    typedef struct packed {
        logic          is_push;
        logic          direct;      // result known without a walk
        t_status       status;
        logic [5:0]    client;
        logic [31:0]   want;
        logic [31:0]   px;
        logic [31:0]   py;
        logic [31:0]   pz;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_IDLE, BS_PUSH, BS_START, BS_RD, BS_CMP, BS_DIV, BS_MUL, BS_ADD, BS_OLD,
        BS_OUT
    } t_bstate;
endpackage
`default_nettype wire

### design/tphr_front.sv
// Front end: accepts requests, applies the recency check and window clamp.
// Depends on tphr_pkg; holds the two-entry command queue that feeds the back end.
`default_nettype none
module tphr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [0:0]     i_req_type,
    input  wire logic [5:0]     i_client,
    input  wire logic [31:0]    i_time,
    input  wire logic [31:0]    i_now,
    input  wire logic [31:0]    i_px,
    input  wire logic [31:0]    i_py,
    input  wire logic [31:0]    i_pz,
    input  wire logic [9:0]     i_frame_len,
    input  wire logic [15:0]    i_max_rewind,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready,
    output tphr_pkg::t_cmd      o_cmd
);
    import tphr_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd n_cmd;
    logic signed [32:0] gap, lo, wclamp;
    logic push_in, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_in     = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        gap = $signed({i_now[31], i_now}) - $signed({i_time[31], i_time});
        lo  = $signed({i_now[31], i_now}) - $signed({17'd0, i_max_rewind});
        wclamp = $signed({i_time[31], i_time});
        if (wclamp < lo) wclamp = lo;
        if (wclamp > $signed({i_now[31], i_now})) wclamp = $signed({i_now[31], i_now});
        n_cmd = '0;
        n_cmd.is_push = (i_req_type == REQ_PUSH);
        n_cmd.client = i_client;
        n_cmd.px = i_px; n_cmd.py = i_py; n_cmd.pz = i_pz;
        n_cmd.status = ST_NOHIST;
        if (n_cmd.is_push) begin
            n_cmd.want = i_time;
        end else if (gap <= $signed({23'd0, i_frame_len})) begin
            n_cmd.direct = 1'b1;
            n_cmd.status = ST_RECENT;
            n_cmd.want = i_time;
        end else begin
            n_cmd.want = wclamp[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_in) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push_in) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_in} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### design/tphr_back.sv
// Back end: ring store, newest-to-oldest walk, serial divide and interpolation.
// Depends on tphr_pkg; drives the registered result stage.
`default_nettype none
module tphr_back #(
    parameter int NUM_CLIENTS   = tphr_pkg::NumClientsDef,
    parameter int HISTORY_DEPTH = tphr_pkg::HistoryDepthDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire tphr_pkg::t_cmd i_cmd,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output logic [1:0]          o_status,
    output logic [31:0]         o_time,
    output logic [31:0]         o_x,
    output logic [31:0]         o_y,
    output logic [31:0]         o_z,
    output logic                o_busy
);
    import tphr_pkg::*;
    localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = CW + HW;
    localparam logic [HW-1:0] HMAX = HW'(HISTORY_DEPTH - 1);

    logic [127:0] mem [2**AW];
    logic [HW-1:0] r_head [NUM_CLIENTS];
    logic [FW-1:0] r_fill [NUM_CLIENTS];

    t_bstate r_st, n_st;
    t_cmd r_cmd;
    logic [HW-1:0] r_idx, r_k, r_n;
    logic [127:0] r_rd, r_b;
    logic [AW-1:0] rd_addr;
    logic rd_en;
    logic [CW-1:0] cl;
    logic in_range;
    logic [HW-1:0] h_next, h_prev, idx_prev;
    // divider
    logic [48:0] r_num;
    logic [32:0] r_den, r_rem;
    logic [16:0] r_f;
    logic [5:0]  r_dcnt;
    logic [1:0]  r_c;
    logic signed [33:0] r_diff;
    logic [31:0] r_res [3];
    logic signed [32:0] a_t, b_t, want_s;

    assign cl = CW'(r_cmd.client);
    assign in_range = ({26'd0, r_cmd.client} < 32'(NUM_CLIENTS));
    assign o_cmd_ready = (r_st == BS_IDLE) && !o_res_valid;
    assign o_busy = (r_st != BS_IDLE);

    // ring slot arithmetic wraps at the ring depth
    assign h_next   = (r_head[cl] == HMAX) ? '0 : r_head[cl] + HW'(1);
    assign h_prev   = (r_head[cl] == '0) ? HMAX : r_head[cl] - HW'(1);
    assign idx_prev = (r_idx == '0) ? HMAX : r_idx - HW'(1);

    assign a_t = $signed({r_rd[31], r_rd[31:0]});
    assign b_t = $signed({r_b[31], r_b[31:0]});
    assign want_s = $signed({r_cmd.want[31], r_cmd.want});

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BS_IDLE:  if (i_cmd_valid && o_cmd_ready)
                          n_st = i_cmd.is_push ? BS_PUSH : (i_cmd.direct ? BS_OUT : BS_START);
            BS_PUSH:  n_st = BS_IDLE;
            BS_START: n_st = BS_RD;
            BS_RD:    n_st = BS_CMP;
            BS_CMP:   n_st = BS_RD;
            BS_DIV:   n_st = (r_dcnt == 6'd0) ? BS_MUL : BS_DIV;
            BS_MUL:   n_st = BS_ADD;
            BS_ADD:   n_st = (r_c == 2'd2) ? BS_OUT : BS_MUL;
            BS_OLD:   n_st = BS_OUT;
            BS_OUT:   n_st = BS_IDLE;
            default:  n_st = BS_IDLE;
        endcase
        // overrides decided by data
        if (r_st == BS_START && (!in_range || r_fill[cl] < FW'(2))) n_st = BS_OUT;
        if (r_st == BS_CMP) begin
            if (a_t <= want_s && want_s <= b_t) n_st = BS_DIV;
            else if (r_k == r_n) n_st = BS_OLD;
        end
    end

    // START fetches the newest sample, each RD fetches the next older one
    always_comb begin
        rd_en = (r_st == BS_START) || (r_st == BS_RD);
        rd_addr = (r_st == BS_START) ? {cl, r_head[cl]} : {cl, r_idx};
    end

    always_ff @(posedge i_clk) begin
        if (r_st == BS_PUSH && in_range)
            mem[{cl, h_next}] <= {r_cmd.pz, r_cmd.py, r_cmd.px, r_cmd.want};
        if (rd_en) r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == BS_IDLE && i_cmd_valid && o_cmd_ready) r_cmd <= i_cmd;
        unique case (r_st)
            BS_START: begin
                // r_n: last pair index = fill-1; r_idx walks down from head-1
                r_n  <= HW'(r_fill[cl] - FW'(1));
                r_idx <= h_prev;
                r_k  <= '0;
            end
            BS_RD: begin
                // shift the older sample into the newer slot
                r_b <= r_rd;
                r_idx <= idx_prev;
                r_k <= r_k + HW'(1);
            end
            BS_CMP: begin
                r_num <= {1'b0, 16'(0), 32'(want_s - a_t)} << 16;
                r_den <= 33'(b_t - a_t);
                r_rem <= '0; r_f <= '0; r_dcnt <= 6'd48;
                r_c <= 2'd0;
            end
            BS_DIV: begin
                logic [33:0] t;
                t = {r_rem, r_num[48]};
                if (r_den != '0 && t >= {1'b0, r_den}) begin
                    r_rem <= 33'(t - {1'b0, r_den});
                    r_f <= {r_f[15:0], 1'b1};
                end else begin
                    r_rem <= t[32:0];
                    r_f <= {r_f[15:0], 1'b0};
                end
                r_num <= {r_num[47:0], 1'b0};
                r_dcnt <= r_dcnt - 6'd1;
            end
            BS_MUL: begin
                r_diff <= $signed({r_b[32*r_c+63], r_b[32*r_c+32 +: 32]})
                        - $signed({r_rd[32*r_c+63], r_rd[32*r_c+32 +: 32]});
            end
            BS_ADD: begin
                logic signed [51:0] p;
                p = r_diff * $signed({1'b0, (r_f > 17'd65536) ? 17'd65536 : r_f});
                r_res[r_c] <= 32'($signed(r_rd[32*r_c+32 +: 32]) + (p >>> 16));
                r_c <= r_c + 2'd1;
            end
            default: ;
        endcase
        if (r_st == BS_OUT) begin
            o_time <= r_cmd.want;
            if (r_cmd.direct || !in_range) begin
                o_status <= r_cmd.status; o_x <= '0; o_y <= '0; o_z <= '0;
            end else if (r_st == BS_OUT && r_k == '0) begin
                o_status <= ST_NOHIST; o_x <= '0; o_y <= '0; o_z <= '0;
            end else begin
                o_status <= r_cmd.status;
                o_x <= r_res[0]; o_y <= r_res[1]; o_z <= r_res[2];
            end
        end
        if (r_st == BS_OLD) begin
            if (want_s < a_t) begin
                r_cmd.status <= ST_OLDEST;
                r_res[0] <= r_rd[63:32]; r_res[1] <= r_rd[95:64]; r_res[2] <= r_rd[127:96];
            end else begin
                r_cmd.status <= ST_NOHIST;
                r_res[0] <= '0; r_res[1] <= '0; r_res[2] <= '0;
            end
        end
        if (r_st == BS_ADD && r_c == 2'd2) r_cmd.status <= ST_INTERP;
        if (r_st == BS_START) r_cmd.status <= ST_NOHIST;
        if (!i_rst_n) begin
            r_st <= BS_IDLE;
            o_res_valid <= 1'b0;
            r_head <= '{default: '0};
            r_fill <= '{default: '0};
        end else begin
            r_st <= n_st;
            if (r_st == BS_OUT) o_res_valid <= 1'b1;
            else if (i_res_ready) o_res_valid <= 1'b0;
            if (r_st == BS_PUSH && in_range) begin
                r_head[cl] <= h_next;
                if (r_fill[cl] != FW'(HISTORY_DEPTH))
                    r_fill[cl] <= r_fill[cl] + FW'(1);
            end
        end
    end
endmodule
`default_nettype wire

### design/timestamped_position_history_rewind_core.sv
// Lag-compensation history core. A push is taken by the back end, then stored in the ring;
// a lookup has a start step, then a memory read and a compare per ring pair walked, and,
// once a pair brackets the wanted time, a serial divide and interpolation. A too-recent
// lookup goes from the command queue straight to the result stage, with no walk. The back
// end takes no new command while a result waits, and a two-entry command queue parts
// front and back.
`default_nettype none
module timestamped_position_history_rewind_core #(
    parameter int NUM_CLIENTS   = tphr_pkg::NumClientsDef,
    parameter int HISTORY_DEPTH = tphr_pkg::HistoryDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: client_index[5:0], time_ms[37:6], now_ms[69:38], pos_x, pos_y, pos_z; pad to 168
    input  wire logic [167:0] s_axis_tdata,
    input  wire logic [0:0]  s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: rewind_time_ms[31:0], out_x, out_y, out_z
    output logic [127:0]     m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // status
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import tphr_pkg::*;
    logic [9:0] r_frame; logic [15:0] r_maxrw;
    t_cmd cmd; logic cmd_v, cmd_r, busy;
    logic [31:0] ot, ox, oy, oz; logic [1:0] ost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FRAME_LEN_RST; r_maxrw <= MAX_REWIND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_LEN:  r_frame <= i_cfg_data[9:0];
                CFG_MAX_REWIND: r_maxrw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tphr_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser), .i_client(s_axis_tdata[5:0]),
        .i_time(s_axis_tdata[37:6]), .i_now(s_axis_tdata[69:38]),
        .i_px(s_axis_tdata[101:70]), .i_py(s_axis_tdata[133:102]),
        .i_pz(s_axis_tdata[165:134]), .i_frame_len(r_frame), .i_max_rewind(r_maxrw),
        .o_cmd_valid(cmd_v), .i_cmd_ready(cmd_r), .o_cmd(cmd)
    );

    tphr_back #(.NUM_CLIENTS(NUM_CLIENTS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_v), .o_cmd_ready(cmd_r), .i_cmd(cmd),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_status(ost), .o_time(ot), .o_x(ox), .o_y(oy), .o_z(oz), .o_busy(busy)
    );
    assign m_axis_tdata = {oz, oy, ox, ot};
    assign m_axis_tuser = ost;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_no_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_r |-> !busy) else $error("command taken while busy");
endmodule
`default_nettype wire
